FILE: rtl/core/pop3rsp_pkg.sv
// POP3 reply stream parser: shared types, result codes and prefix tables.
// No dependencies; imported by pop3rsp_parse and pop3_reply_stream_parser.
package pop3rsp_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       expect_multiline;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       reply_ok;
    logic       burst_last;
  } out_t;

  // Up to three results come from one input byte
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    out_t [MaxResults-1:0] res;
    logic [1:0]            count;
  } burst_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_AFTER,
    PH_REST,
    PH_BAD,
    PH_BSTART,
    PH_BMID
  } phase_t;

  localparam logic [2:0] KIND_MSG  = 3'd0;
  localparam logic [2:0] KIND_BODY = 3'd1;
  localparam logic [2:0] KIND_EOL  = 3'd2;
  localparam logic [2:0] KIND_DONE = 3'd3;
  localparam logic [2:0] KIND_BAD  = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // "+OK", indexed modulo its length
  function automatic logic [7:0] ok_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd1:    c = 8'h4F;
      2'd2:    c = 8'h4B;
      default: c = CH_PLUS;
    endcase
    return c;
  endfunction

  // "-ERR"
  function automatic logic [7:0] err_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_MINUS;
      2'd1:    c = 8'h45;
      default: c = 8'h52;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/pop3_reply_stream_parser.sv
// POP3 reply stream parser, top level: parser plus a two-slot result buffer.
// Depends on pop3rsp_pkg and pop3rsp_parse.
//
// Usage:
//   in_valid/in_ready/in_data carry one reply byte and the multiline flag per
//   transaction. out_valid/out_ready/out_data carry one result per transaction;
//   burst_last marks the final result caused by an input byte. Bytes that
//   cause no result (prefix, dropped text, held CR or dot) are absorbed.
//   A byte's results are registered into the result register when that is
//   free, else into the second slot. Throughput: one byte per cycle while each
//   byte gives at most one result and out_ready stays high; a byte giving two
//   or three results holds the output while the single result register drains
//   one per cycle. A following burst waits in the second slot, so input is taken
//   while a result is still waiting; in_ready falls only when that slot is full.
//   Receiver stall: out_data holds; input stalls once both slots are full.
//   Reset: the parser returns to idle awaiting a new reply, both slots empty.
module pop3_reply_stream_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pop3rsp_pkg::in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pop3rsp_pkg::out_t out_data
);
  import pop3rsp_pkg::*;

  burst_t     new_burst;
  burst_t     cur, pend;
  logic       cur_valid, pend_valid;
  logic [1:0] cur_idx;
  logic       accept, new_has, take, last_take, cur_free;

  assign in_ready  = !pend_valid;
  assign accept    = in_valid && in_ready;
  assign new_has   = accept && (new_burst.count != 2'd0);
  assign out_valid = cur_valid;
  assign out_data  = cur.res[cur_idx];
  assign take      = cur_valid && out_ready;
  assign last_take = take && (cur_idx == cur.count - 2'd1);
  assign cur_free  = !cur_valid || last_take;

  pop3rsp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .burst   (new_burst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
      cur_idx    <= '0;
    end else if (cur_free) begin
      cur_idx <= '0;
      if (pend_valid) begin
        cur        <= pend;
        cur_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (new_has) begin
        cur       <= new_burst;
        cur_valid <= 1'b1;
      end else begin
        cur_valid <= 1'b0;
      end
    end else begin
      if (take) cur_idx <= cur_idx + 2'd1;
      if (new_has) begin
        pend       <= new_burst;
        pend_valid <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/pop3rsp_parse.sv
// Parser state machine: holds the reply state and forms the burst of results
// for the byte being accepted. Depends on pop3rsp_pkg.
module pop3rsp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  pop3rsp_pkg::in_t     in_data,
  output pop3rsp_pkg::burst_t  burst
);
  import pop3rsp_pkg::*;

  phase_t     phase, phase_next;
  logic [2:0] prefix_count, prefix_count_next;
  logic       status_ok, status_ok_next;
  logic       multiline_latched, multiline_latched_next;
  logic       cr_pending, cr_pending_next;
  logic       dot_pending, dot_pending_next;
  logic       forward_message, forward_message_next;

  logic [7:0] b;
  logic       cr_lf;
  phase_t     ph_e;
  logic       dot_e;

  assign b = in_data.rx_byte;

  // A held CR that is not a line end pushes a body line start into mid-line
  always_comb begin
    cr_lf = cr_pending && (b == CH_LF);
    ph_e  = phase;
    dot_e = dot_pending;
    if (cr_pending && !cr_lf && phase == PH_BSTART) begin
      ph_e  = PH_BMID;
      dot_e = 1'b0;
    end
  end

  // Next state
  always_comb begin
    logic [1:0] idx;
    logic [2:0] len;
    logic [7:0] want;
    phase_next             = ph_e;
    prefix_count_next      = prefix_count;
    status_ok_next         = status_ok;
    multiline_latched_next = multiline_latched;
    cr_pending_next        = 1'b0;
    dot_pending_next       = dot_e;
    forward_message_next   = forward_message;
    idx  = prefix_count[1:0];
    len  = status_ok ? 3'd3 : 3'd4;
    want = status_ok ? ok_char(idx) : err_char(idx);
    if (cr_lf) begin
      phase_next = phase;
      unique case (phase)
        PH_BAD: phase_next = PH_IDLE;
        PH_REST: begin
          if (status_ok && multiline_latched) begin
            phase_next       = PH_BSTART;
            dot_pending_next = 1'b0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_BSTART: begin
          if (dot_pending) begin
            dot_pending_next = 1'b0;
            phase_next       = PH_IDLE;
          end else begin
            phase_next = PH_BSTART;
          end
        end
        PH_BMID: phase_next = PH_BSTART;
        default: phase_next = phase;
      endcase
    end else begin
      unique case (ph_e)
        PH_PREFIX: begin
          if ({1'b0, idx} < len && b == want) begin
            prefix_count_next = {1'b0, idx} + 3'd1;
            if (prefix_count_next >= len) phase_next = PH_AFTER;
          end else begin
            phase_next      = PH_BAD;
            status_ok_next  = 1'b0;
            cr_pending_next = (b == CH_CR);
          end
        end
        PH_AFTER: begin
          phase_next           = PH_REST;
          forward_message_next = (b == CH_SPACE);
          cr_pending_next      = (b == CH_CR);
        end
        PH_REST: cr_pending_next = (b == CH_CR);
        PH_BAD:  cr_pending_next = (b == CH_CR);
        PH_BSTART: begin
          if (dot_e) begin
            if (b == CH_CR) begin
              cr_pending_next = 1'b1;
            end else begin
              dot_pending_next = 1'b0;
              phase_next       = PH_BMID;
            end
          end else if (b == CH_DOT) begin
            dot_pending_next = 1'b1;
          end else if (b == CH_CR) begin
            cr_pending_next = 1'b1;
          end else begin
            phase_next = PH_BMID;
          end
        end
        PH_BMID: cr_pending_next = (b == CH_CR);
        default: begin
          multiline_latched_next = in_data.expect_multiline;
          forward_message_next   = 1'b0;
          dot_pending_next       = 1'b0;
          prefix_count_next      = 3'd1;
          if (b == CH_PLUS) begin
            status_ok_next = 1'b1;
            phase_next     = PH_PREFIX;
          end else if (b == CH_MINUS) begin
            status_ok_next = 1'b0;
            phase_next     = PH_PREFIX;
          end else begin
            status_ok_next    = 1'b0;
            prefix_count_next = 3'd0;
            phase_next        = PH_BAD;
            cr_pending_next   = (b == CH_CR);
          end
        end
      endcase
    end
  end

  // Results for this byte
  always_comb begin
    logic [1:0] n;
    n     = 2'd0;
    burst = '0;
    if (cr_pending) begin
      if (cr_lf) begin
        unique case (phase)
          PH_BAD: begin
            burst.res[n].kind = KIND_BAD;
            n = n + 2'd1;
          end
          PH_REST: begin
            if (!(status_ok && multiline_latched)) begin
              burst.res[n].kind     = KIND_DONE;
              burst.res[n].reply_ok = status_ok;
              n = n + 2'd1;
            end
          end
          PH_BSTART, PH_BMID: begin
            burst.res[n].kind     = (phase == PH_BSTART && dot_pending) ? KIND_DONE
                                                                         : KIND_EOL;
            burst.res[n].reply_ok = status_ok;
            n = n + 2'd1;
          end
          default: n = 2'd0;
        endcase
      end else if (phase == PH_REST) begin
        if (forward_message) begin
          burst.res[n] = '{kind: KIND_MSG, out_byte: CH_CR, reply_ok: status_ok,
                           burst_last: 1'b0};
          n = n + 2'd1;
        end
      end else if (phase == PH_BSTART || phase == PH_BMID) begin
        if (phase == PH_BSTART && dot_pending) begin
          burst.res[n] = '{kind: KIND_BODY, out_byte: CH_DOT, reply_ok: status_ok,
                           burst_last: 1'b0};
          n = n + 2'd1;
        end
        burst.res[n] = '{kind: KIND_BODY, out_byte: CH_CR, reply_ok: status_ok,
                         burst_last: 1'b0};
        n = n + 2'd1;
      end
    end
    if (!cr_lf) begin
      unique case (ph_e)
        PH_REST: begin
          if (b != CH_CR && forward_message) begin
            burst.res[n] = '{kind: KIND_MSG, out_byte: b, reply_ok: status_ok,
                             burst_last: 1'b0};
            n = n + 2'd1;
          end
        end
        PH_BSTART: begin
          if (dot_e && b != CH_CR) begin
            burst.res[n] = '{kind: KIND_BODY, out_byte: CH_DOT, reply_ok: status_ok,
                             burst_last: 1'b0};
            n = n + 2'd1;
          end
          // a held dot is sent above and a second dot is swallowed here; a first dot is held back
          if (b != CH_CR && b != CH_DOT) begin
            burst.res[n] = '{kind: KIND_BODY, out_byte: b, reply_ok: status_ok,
                             burst_last: 1'b0};
            n = n + 2'd1;
          end
        end
        PH_BMID: begin
          if (b != CH_CR) begin
            burst.res[n] = '{kind: KIND_BODY, out_byte: b, reply_ok: status_ok,
                             burst_last: 1'b0};
            n = n + 2'd1;
          end
        end
        default: n = n;
      endcase
    end
    if (n != 2'd0) burst.res[n - 2'd1].burst_last = 1'b1;
    burst.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      prefix_count      <= '0;
      status_ok         <= 1'b0;
      multiline_latched <= 1'b0;
      cr_pending        <= 1'b0;
      dot_pending       <= 1'b0;
      forward_message   <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      prefix_count      <= prefix_count_next;
      status_ok         <= status_ok_next;
      multiline_latched <= multiline_latched_next;
      cr_pending        <= cr_pending_next;
      dot_pending       <= dot_pending_next;
      forward_message   <= forward_message_next;
    end
  end

endmodule
